// ===== design/sacs_pkg.sv =====
// ----------------------------------------------------------------------------
// sacs_pkg
// Types and constants shared by the SPI ADC conversion sequencer.
// ----------------------------------------------------------------------------
package sacs_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_WAIT = 2'd2,
        PH_RECV = 2'd3
    } phase_t;

    localparam logic [7:0]  CMD_BASE       = 8'b1000_0100;
    localparam int          FRAME_BITS     = 16;
    localparam int          BIT_CNT_W      = 5;
    localparam int          WORD_W         = 16;
    localparam logic [15:0] WAIT_RESET     = 16'd4;

    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;
    typedef logic [WORD_W-1:0]    word_t;

    // Command byte: bit 6 carries the channel's low bit, bits 5..4 its upper bits.
    function automatic logic [7:0] cmd_byte(input logic [2:0] ch);
        logic [7:0] c;
        c = CMD_BASE;
        c[6] = ch[0];
        c[5:4] = ch[2:1];
        return c;
    endfunction

endpackage

// ===== design/sacs_ifs.sv =====
// ----------------------------------------------------------------------------
// sacs channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface sacs_tick_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [2:0] channel;
    logic       miso_level;

    modport source (output valid, output start_req, output channel, output miso_level,
                    input ready);
    modport sink   (input valid, input start_req, input channel, input miso_level,
                    output ready);
endinterface

interface sacs_result_if;
    logic        valid;
    logic        ready;
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    logic        busy_res;
    logic        done_res;
    logic [15:0] sample;

    modport source (output valid, output cs_n, output sclk, output mosi,
                    output busy_res, output done_res, output sample, input ready);
    modport sink   (input valid, input cs_n, input sclk, input mosi,
                    input busy_res, input done_res, input sample, output ready);
endinterface

interface sacs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/spi_adc_conversion_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// spi_adc_conversion_sequencer_unit
// Pin-level SPI master that reads one channel of an eight-channel ADC.
// ----------------------------------------------------------------------------
// Each tick word is one half period of the serial clock and yields exactly one
// result word holding the pin levels after that tick. A start while idle sends
// the command byte and a zero byte with chip select low, holds chip select high
// for conversion_wait_ticks ticks (at least one), then clocks in 16 bits MSB
// first and flags the sample with done_res. A tick word is taken every cycle:
// the sequencer state updates in one pass of logic and the result lands in an
// output register, so the block stalls only while that register is full and
// its word is not taken. The wait count is loaded from the register at the end
// of each command frame.
module spi_adc_conversion_sequencer_unit (
    input  logic           clk,
    input  logic           rst_n,
    sacs_tick_if.sink      tick,
    sacs_result_if.source  result,
    sacs_cfg_if.sink       cfg
);

    // sequencer state
    sacs_pkg::phase_t   phase_reg, phase_next;
    sacs_pkg::bit_cnt_t bit_cnt_reg, bit_cnt_next;
    logic               sclk_reg, sclk_next;
    logic               cs_reg, cs_next;
    logic               mosi_reg, mosi_next;
    logic [15:0]        cmd_reg, cmd_next;
    logic [15:0]        rx_reg, rx_next;
    logic [15:0]        wait_reg, wait_next;
    logic [15:0]        wait_ticks_reg;

    // result register
    logic               res_valid_reg;
    logic               res_cs_reg, res_sclk_reg, res_mosi_reg;
    logic               res_busy_reg, res_done_reg;
    logic [15:0]        res_sample_reg;

    logic               tick_acc;
    logic               done_next;
    sacs_pkg::bit_cnt_t bit_cnt_inc;
    logic [15:0]        wait_dec;
    logic               frame_end;

    assign tick.ready  = !res_valid_reg || result.ready;
    assign tick_acc    = tick.valid && tick.ready;
    assign cfg.ready   = 1'b1;

    assign bit_cnt_inc = bit_cnt_reg + sacs_pkg::bit_cnt_t'(1);
    assign frame_end   = bit_cnt_inc >= sacs_pkg::bit_cnt_t'(sacs_pkg::FRAME_BITS);
    assign wait_dec    = (wait_reg != 16'd0) ? wait_reg - 16'd1 : wait_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            sacs_pkg::PH_IDLE:
            begin
                if (tick.start_req)
                begin
                    phase_next = sacs_pkg::PH_SEND;
                end
            end
            sacs_pkg::PH_SEND:
            begin
                if (sclk_reg && frame_end)
                begin
                    phase_next = sacs_pkg::PH_WAIT;
                end
            end
            sacs_pkg::PH_WAIT:
            begin
                if (wait_dec == 16'd0)
                begin
                    phase_next = sacs_pkg::PH_RECV;
                end
            end
            sacs_pkg::PH_RECV:
            begin
                if (sclk_reg && frame_end)
                begin
                    phase_next = sacs_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = sacs_pkg::PH_IDLE;
            end
        endcase
    end

    // pin levels and shift registers
    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        sclk_next    = sclk_reg;
        cs_next      = cs_reg;
        mosi_next    = mosi_reg;
        cmd_next     = cmd_reg;
        rx_next      = rx_reg;
        wait_next    = wait_reg;
        done_next    = 1'b0;
        unique case (phase_reg)
            sacs_pkg::PH_IDLE:
            begin
                if (tick.start_req)
                begin
                    cmd_next     = {sacs_pkg::cmd_byte(tick.channel), 8'h00};
                    mosi_next    = cmd_next[15];
                    cs_next      = 1'b0;
                    sclk_next    = 1'b0;
                    bit_cnt_next = '0;
                    rx_next      = '0;
                end
            end
            sacs_pkg::PH_SEND:
            begin
                if (!sclk_reg)
                begin
                    sclk_next = 1'b1;
                end
                else
                begin
                    sclk_next    = 1'b0;
                    bit_cnt_next = bit_cnt_inc;
                    if (frame_end)
                    begin
                        cs_next   = 1'b1;
                        wait_next = wait_ticks_reg;
                    end
                    else
                    begin
                        cmd_next  = {cmd_reg[14:0], 1'b0};
                        mosi_next = cmd_reg[14];
                    end
                end
            end
            sacs_pkg::PH_WAIT:
            begin
                wait_next = wait_dec;
                if (wait_dec == 16'd0)
                begin
                    cs_next      = 1'b0;
                    sclk_next    = 1'b0;
                    bit_cnt_next = '0;
                    rx_next      = '0;
                end
            end
            sacs_pkg::PH_RECV:
            begin
                if (!sclk_reg)
                begin
                    sclk_next = 1'b1;
                end
                else
                begin
                    rx_next      = {rx_reg[14:0], tick.miso_level};
                    sclk_next    = 1'b0;
                    bit_cnt_next = bit_cnt_inc;
                    if (frame_end)
                    begin
                        cs_next   = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            default:
            begin
                bit_cnt_next = bit_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sacs_pkg::PH_IDLE;
            bit_cnt_reg    <= '0;
            sclk_reg       <= 1'b0;
            cs_reg         <= 1'b1;
            mosi_reg       <= 1'b1;
            cmd_reg        <= '0;
            rx_reg         <= '0;
            wait_reg       <= '0;
            wait_ticks_reg <= sacs_pkg::WAIT_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                wait_ticks_reg <= cfg.data;
            end
            if (tick_acc)
            begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                sclk_reg      <= sclk_next;
                cs_reg        <= cs_next;
                mosi_reg      <= mosi_next;
                cmd_reg       <= cmd_next;
                rx_reg        <= rx_next;
                wait_reg      <= wait_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with the post-tick pin levels
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            res_cs_reg     <= cs_next;
            res_sclk_reg   <= sclk_next;
            res_mosi_reg   <= mosi_next;
            res_busy_reg   <= phase_next != sacs_pkg::PH_IDLE;
            res_done_reg   <= done_next;
            res_sample_reg <= done_next ? rx_next : 16'd0;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.cs_n     = res_cs_reg;
    assign result.sclk     = res_sclk_reg;
    assign result.mosi     = res_mosi_reg;
    assign result.busy_res = res_busy_reg;
    assign result.done_res = res_done_reg;
    assign result.sample   = res_sample_reg;

`ifndef SYNTHESIS
    a_done_deselects: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_done_reg) |-> (res_cs_reg && !res_busy_reg))
        else $error("done word without chip select released");

    a_wait_cs_high: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sacs_pkg::PH_WAIT) |-> cs_reg)
        else $error("chip select low during conversion wait");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= sacs_pkg::bit_cnt_t'(sacs_pkg::FRAME_BITS))
        else $error("bit counter beyond frame length");

    a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_acc && phase_reg == sacs_pkg::PH_IDLE && tick.start_req)
        |=> (phase_reg == sacs_pkg::PH_SEND && !cs_reg))
        else $error("start from idle did not open command frame");

    a_sample_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_done_reg) |-> (res_sample_reg == 16'd0))
        else $error("sample word nonzero without done");
`endif

endmodule
